FILE: hw/rtl/positional_list_engine_assert.svh
// ----------------------------------------------------------------------------
// Positional list engine assertion macros
// Concurrent assertion wrappers clocked on clk_i; PLE_ASSERT is disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_ASSERT_SVH

// Assertion disabled while reset is asserted.
`define PLE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Assertion checked during reset as well.
`define PLE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: hw/rtl/ple_pkg.sv
// ----------------------------------------------------------------------------
// Positional list engine package
// Opcodes, status codes, cell control and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package ple_pkg;

  localparam int unsigned CAPACITY_DEF   = 16;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_REMOVE = 3'd1,
    OP_READ   = 3'd2,
    OP_WRITE  = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  // Per-cell load select; all low means hold.
  typedef struct packed {
    logic take_left;
    logic take_right;
    logic take_new;
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ple_cell.sv
// ----------------------------------------------------------------------------
// Positional list engine cell
// One list slot: loads from its left or right neighbor, the new value, or holds.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_cell #(
  parameter int unsigned DATA_WIDTH = ple_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                   clk_i,
  input  wire ple_pkg::cell_ctrl_t    ctrl_i,
  input  wire logic [DATA_WIDTH-1:0]  left_i,
  input  wire logic [DATA_WIDTH-1:0]  right_i,
  input  wire logic [DATA_WIDTH-1:0]  new_i,
  output logic      [DATA_WIDTH-1:0]  data_o
);

  logic [DATA_WIDTH-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.take_new) begin
      data_d = new_i;
    end else if (ctrl_i.take_left) begin
      data_d = left_i;
    end else if (ctrl_i.take_right) begin
      data_d = right_i;
    end
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

FILE: hw/rtl/positional_list_engine.sv
// ----------------------------------------------------------------------------
// Positional list engine
// Ordered list of up to CAPACITY entries addressed by 1-based position, held in
// a row of cells that shift toward each other on insert and remove.
// ----------------------------------------------------------------------------
// The result is registered: result valid rises in the cycle after the input transfer.
// Throughput: 1 request per cycle; the shifting cells load their neighbors in parallel.
// A new request is taken while a result waits, as long as out_ready_i is high.
// Reset: asynchronous, active low; clears the entry count and result valid.
// Entry contents are not reset; positions beyond the count are never returned.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_engine #(
  parameter int unsigned CAPACITY   = ple_pkg::CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = ple_pkg::DATA_WIDTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  op_i,
  input  wire logic [4:0]  position_i,
  input  wire logic [31:0] value_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      read_value_o,
  output logic [1:0]       status_o,
  output logic [4:0]       list_length_o
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W = $clog2(CAPACITY);
  // compare width: holds count+1 and any position without overflow
  localparam int unsigned CW    = ((CNT_W > 5) ? CNT_W : 5) + 1;

  // --------------------------------------------------------------------------
  // Control state
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q;
  logic             accept;

  // registered result
  logic [31:0]      read_value_q, read_value_d;
  ple_pkg::status_e status_q, status_d;
  logic [4:0]       list_length_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // --------------------------------------------------------------------------
  // Position checks, all in a common width
  // --------------------------------------------------------------------------
  logic [CW-1:0]    pos_w, cnt_w, pos_m1;
  logic [IDX_W-1:0] tgt;
  logic             pos_zero, pos_in_list, pos_in_ins, is_full;

  assign pos_w       = CW'(position_i);
  assign cnt_w       = CW'(count_q);
  assign pos_m1      = pos_w - CW'(1);
  assign tgt         = pos_m1[IDX_W-1:0];
  assign pos_zero    = (pos_w == '0);
  assign pos_in_list = !pos_zero && (pos_w <= cnt_w);
  assign pos_in_ins  = !pos_zero && (pos_w <= cnt_w + CW'(1));
  assign is_full     = (cnt_w == CW'(CAPACITY));

  // --------------------------------------------------------------------------
  // Operation decode
  // --------------------------------------------------------------------------
  logic do_ins, do_rem, do_wr, do_rd;

  always_comb begin
    do_ins   = 1'b0;
    do_rem   = 1'b0;
    do_wr    = 1'b0;
    do_rd    = 1'b0;
    status_d = ple_pkg::ST_OK;
    count_d  = count_q;
    case (ple_pkg::op_e'(op_i))
      ple_pkg::OP_INSERT: begin
        if (!pos_in_ins) begin
          status_d = ple_pkg::ST_BADPOS;
        end else if (is_full) begin
          status_d = ple_pkg::ST_FULL;
        end else begin
          do_ins  = 1'b1;
          count_d = count_q + CNT_W'(1);
        end
      end
      ple_pkg::OP_REMOVE: begin
        if (!pos_in_list) begin
          status_d = ple_pkg::ST_BADPOS;
        end else begin
          do_rem  = 1'b1;
          count_d = count_q - CNT_W'(1);
        end
      end
      ple_pkg::OP_READ: begin
        if (!pos_in_list) begin
          status_d = ple_pkg::ST_BADPOS;
        end else begin
          do_rd = 1'b1;
        end
      end
      ple_pkg::OP_WRITE: begin
        if (!pos_in_list) begin
          status_d = ple_pkg::ST_BADPOS;
        end else begin
          do_wr = 1'b1;
        end
      end
      ple_pkg::OP_CLEAR: begin
        count_d = '0;
      end
      default: begin
        status_d = ple_pkg::ST_BADPOS;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Cell row. Insert: cells past the target take their left neighbor, the
  // target takes the new value. Remove: target and later take the right one.
  // --------------------------------------------------------------------------
  logic [DATA_WIDTH-1:0] new_data;
  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
  logic [CAPACITY-1:0]   rd_hit;

  assign new_data = DATA_WIDTH'(value_i);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    ple_pkg::cell_ctrl_t   ctrl;
    logic [DATA_WIDTH-1:0] left, right;
    logic                  at_tgt, past_tgt;

    assign at_tgt   = (IDX_W'(i) == tgt);
    assign past_tgt = (IDX_W'(i) > tgt);

    assign ctrl.take_new   = accept && (do_ins || do_wr) && at_tgt;
    assign ctrl.take_left  = accept && do_ins && past_tgt;
    assign ctrl.take_right = accept && do_rem && (at_tgt || past_tgt);
    assign rd_hit[i]       = do_rd && at_tgt;

    // ends of the row feed back their own entry
    if (i == 0) begin : g_first
      assign left = cell_data[i];
    end else begin : g_left
      assign left = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = cell_data[i];
    end else begin : g_right
      assign right = cell_data[i+1];
    end

    ple_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .left_i  (left),
      .right_i (right),
      .new_i   (new_data),
      .data_o  (cell_data[i])
    );
  end

  // one-hot read select over the row
  logic [DATA_WIDTH-1:0] rd_data;

  always_comb begin
    rd_data = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      rd_data = rd_data | (cell_data[k] & {DATA_WIDTH{rd_hit[k]}});
    end
  end

  assign read_value_d = 32'(rd_data);

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      if (in_ready_o) begin
        out_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      read_value_q  <= read_value_d;
      status_q      <= status_d;
      list_length_q <= 5'(count_d);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign read_value_o  = read_value_q;
  assign status_o      = status_q;
  assign list_length_o = list_length_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`include "positional_list_engine_assert.svh"

  `PLE_ASSERT(a_count_bound, count_q <= CNT_W'(CAPACITY), "count above capacity")
  `PLE_ASSERT(a_full_means_full, (out_valid_q && status_q == ple_pkg::ST_FULL) |-> (count_q == CNT_W'(CAPACITY)), "full status with room left")
  `PLE_ASSERT(a_stall_holds_list, (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(count_q)), "list changed under stalled result")

endmodule

`default_nettype wire

FILE: dv/positional_list_engine_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Positional list engine testbench
// Drives insert, remove, read, write and clear requests over valid/ready,
// predicts each result with a local list model, and checks every result
// transfer in order. The run covers a directed pass, then random traffic in
// phases of sender idling and receiver stalls, with one long output back-off.
// ----------------------------------------------------------------------------
module positional_list_engine_tb;

  localparam int unsigned LIST_CAP     = ple_pkg::CAPACITY_DEF;
  localparam int unsigned ITEMS_PHASE  = 450;
  localparam int unsigned MIX_SPAN     = 48;   // items per random traffic mix
  localparam int unsigned DRAIN_SLACK  = 8;    // cycles after the last result
  localparam int unsigned HOLD_CYCLES  = 80;   // long output back-off
  localparam logic [2:0]  OP_UNDEF_LO  = 3'd5;
  localparam logic [2:0]  OP_UNDEF_HI  = 3'd7;
  localparam logic [4:0]  POS_MAX      = 5'd31;

  // Traffic mixes for the random part.
  typedef enum int unsigned {
    MIX_EVEN,
    MIX_FILL,
    MIX_DRAIN
  } mix_e;

  typedef struct {
    logic [31:0]      read_value;
    ple_pkg::status_e status;
    logic [4:0]       list_length;
  } list_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: list model plus the queue of results still owed by the block.
  // --------------------------------------------------------------------------
  class list_scoreboard;
    logic [31:0]  slots [LIST_CAP];
    int unsigned  length;
    list_result_t owed [$];
    int unsigned  failures;

    function new();
      length   = 0;
      failures = 0;
    endfunction

    // Apply one accepted request to the model and queue its result.
    function void note_request(logic [2:0] op, logic [4:0] pos, logic [31:0] val);
      list_result_t res;
      int unsigned  p;
      p              = pos;
      res.read_value = '0;
      res.status     = ple_pkg::ST_OK;
      case (op)
        ple_pkg::OP_INSERT: begin
          if (p < 1 || p > length + 1) begin
            res.status = ple_pkg::ST_BADPOS;
          end else if (length >= LIST_CAP) begin
            res.status = ple_pkg::ST_FULL;
          end else begin
            for (int i = length; i >= int'(p); i--) slots[i] = slots[i-1];
            slots[p-1] = val;
            length++;
          end
        end
        ple_pkg::OP_REMOVE: begin
          if (p < 1 || p > length) begin
            res.status = ple_pkg::ST_BADPOS;
          end else begin
            for (int i = p; i < int'(length); i++) slots[i-1] = slots[i];
            length--;
          end
        end
        ple_pkg::OP_READ: begin
          if (p < 1 || p > length) res.status = ple_pkg::ST_BADPOS;
          else res.read_value = slots[p-1];
        end
        ple_pkg::OP_WRITE: begin
          if (p < 1 || p > length) res.status = ple_pkg::ST_BADPOS;
          else slots[p-1] = val;
        end
        ple_pkg::OP_CLEAR: begin
          length = 0;
        end
        default: begin
          res.status = ple_pkg::ST_BADPOS;
        end
      endcase
      res.list_length = length[4:0];
      owed.push_back(res);
    endfunction

    // Compare one result transfer against the oldest owed result.
    function void check_result(logic [31:0] rd, logic [1:0] st, logic [4:0] len);
      list_result_t res;
      if (owed.size() == 0) begin
        $display("%0t: result with nothing owed: read_value %h status %0d length %0d",
                 $time, rd, st, len);
        failures++;
        return;
      end
      res = owed.pop_front();
      if (rd !== res.read_value) begin
        $display("%0t: read_value expected %h actual %h", $time, res.read_value, rd);
        failures++;
      end
      if (st !== res.status) begin
        $display("%0t: status expected %0d actual %0d", $time, res.status, st);
        failures++;
      end
      if (len !== res.list_length) begin
        $display("%0t: list_length expected %0d actual %0d",
                 $time, res.list_length, len);
        failures++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and block under test
  // --------------------------------------------------------------------------
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  op_i = ple_pkg::OP_READ;
  logic [4:0]  position_i = '0;
  logic [31:0] value_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] read_value_o;
  logic [1:0]  status_o;
  logic [4:0]  list_length_o;

  list_scoreboard sb = new();

  // Idle and stall rates in percent, set per phase by the main sequence.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  // Cycles left in a forced output back-off; counted down by the receiver.
  int unsigned hold_left      = 0;

  positional_list_engine u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .position_i    (position_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .read_value_o  (read_value_o),
    .status_o      (status_o),
    .list_length_o (list_length_o)
  );

  // 4 ns clock.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Receiver: random stalls, or a long back-off while hold_left runs down.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left   =  hold_left - 1;
    end else begin
      out_ready_i <= ($urandom_range(1, 100) > recv_stall_pct);
    end
  end

  // Result monitor. Sampled at the edge, so it sees the pre-edge values.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result(read_value_o, status_o, list_length_o);
    end
  end

  // Offer one request and hold it until its transfer. Valid is only lowered
  // on an idle cycle, so back-to-back requests keep it high.
  task automatic send_request(input logic [2:0] op, input logic [4:0] pos,
                              input logic [31:0] val);
    while ($urandom_range(1, 100) <= send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    position_i <= pos;
    value_i    <= val;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(op, pos, val);
  endtask

  // Directed pass: field extremes, every op and the error paths.
  task automatic run_directed();
    send_request(ple_pkg::OP_READ,   5'd1, '0);            // read of an empty list
    send_request(ple_pkg::OP_REMOVE, 5'd1, '0);            // remove from an empty list
    send_request(ple_pkg::OP_WRITE,  5'd1, '1);            // write to an empty list
    send_request(ple_pkg::OP_INSERT, 5'd0, '1);            // insert at position zero
    send_request(ple_pkg::OP_INSERT, 5'd2, '1);            // insert past length+1
    send_request(ple_pkg::OP_INSERT, 5'd1, 32'hFFFF_FFFF);
    send_request(ple_pkg::OP_INSERT, 5'd1, 32'h0000_0000); // new head
    send_request(ple_pkg::OP_INSERT, 5'd3, 32'hA5A5_A5A5); // append at tail
    send_request(ple_pkg::OP_READ,   5'd1, '0);
    send_request(ple_pkg::OP_READ,   5'd2, '0);
    send_request(ple_pkg::OP_READ,   5'd3, '0);
    send_request(ple_pkg::OP_READ,   5'd4, '0);            // one past the end
    send_request(ple_pkg::OP_WRITE,  5'd2, 32'h5A5A_5A5A);
    send_request(ple_pkg::OP_READ,   5'd2, '0);
    send_request(ple_pkg::OP_REMOVE, 5'd2, '0);            // middle entry
    send_request(ple_pkg::OP_READ,   5'd2, '0);
    send_request(ple_pkg::OP_REMOVE, POS_MAX, '0);
    for (logic [3:0] u = OP_UNDEF_LO; u <= OP_UNDEF_HI; u++) begin
      send_request(u[2:0], 5'd1, $urandom());
    end
    send_request(ple_pkg::OP_CLEAR,  POS_MAX, $urandom()); // position and value unused
    send_request(ple_pkg::OP_READ,   5'd1, '0);
    send_request(ple_pkg::OP_INSERT, POS_MAX, '1);
  endtask

  // Random traffic. Each span of items favors growing, shrinking or a mix,
  // so the list swings between empty and full. Most positions are legal.
  task automatic run_random(input int unsigned n);
    mix_e        mix;
    int unsigned roll;
    int unsigned w_ins, w_rem, w_rd, w_wr, w_clr;
    logic [2:0]  op;
    logic [4:0]  pos;
    int unsigned len;
    mix = MIX_EVEN;
    for (int unsigned k = 0; k < n; k++) begin
      if (k % MIX_SPAN == 0) mix = mix_e'($urandom_range(0, 2));
      case (mix)
        MIX_FILL:  begin w_ins = 70; w_rem = 6;  w_rd = 12; w_wr = 10; w_clr = 0; end
        MIX_DRAIN: begin w_ins = 10; w_rem = 55; w_rd = 15; w_wr = 15; w_clr = 2; end
        default:   begin w_ins = 30; w_rem = 25; w_rd = 20; w_wr = 17; w_clr = 4; end
      endcase
      roll = $urandom_range(1, 100);
      if (roll <= w_ins) op = ple_pkg::OP_INSERT;
      else if (roll <= w_ins + w_rem) op = ple_pkg::OP_REMOVE;
      else if (roll <= w_ins + w_rem + w_rd) op = ple_pkg::OP_READ;
      else if (roll <= w_ins + w_rem + w_rd + w_wr) op = ple_pkg::OP_WRITE;
      else if (roll <= w_ins + w_rem + w_rd + w_wr + w_clr) op = ple_pkg::OP_CLEAR;
      else op = 3'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
      len = sb.length;
      if ($urandom_range(1, 100) <= 85) begin
        if (op == ple_pkg::OP_INSERT) pos = 5'($urandom_range(1, len + 1));
        else if (len > 0) pos = 5'($urandom_range(1, len));
        else pos = 5'($urandom_range(0, POS_MAX));
      end else begin
        pos = 5'($urandom_range(0, POS_MAX));
      end
      send_request(op, pos, $urandom());
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();

    // Free-flowing traffic, opened by a long output back-off so the result
    // register fills and the input side stalls.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = HOLD_CYCLES;
    run_random(ITEMS_PHASE);

    send_idle_pct  = 83;
    recv_stall_pct = 0;
    run_random(ITEMS_PHASE);

    send_idle_pct  = 0;
    recv_stall_pct = 83;
    run_random(ITEMS_PHASE);

    send_idle_pct  = 33;
    recv_stall_pct = 33;
    run_random(ITEMS_PHASE);

    in_valid_i     <= 1'b0;
    recv_stall_pct =  0;
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (DRAIN_SLACK) @(posedge clk_i);

    if (sb.failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Run limit, well above the slowest legal run.
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
